@@ hdl/spe_pkg.sv @@
// Package for the sign partition engine.
// Holds the word width, the default store depth and the request and result payload types.
// No dependencies.
package spe_pkg;

  localparam int unsigned WordW        = 32;
  localparam int unsigned DepthDefault = 64;

  typedef struct packed {
    logic signed [WordW-1:0] value;
    logic                    last;
  } req_t;

  typedef struct packed {
    logic signed [WordW-1:0] value_res;
    logic                    last_res;
  } res_t;

endpackage

@@ hdl/sign_partition_engine.sv @@
// Top level of the sign partition engine: loads a list of signed words, partitions
// it by sign in place and emits the whole list in order.
// Depends on spe_pkg and spe_ram.
//
//   Channel   Signals                              Payload
//   request   req_valid_i, req_ready_o, req_i      spe_pkg::req_t (value, last)
//   result    res_valid_o, res_ready_i, res_o      spe_pkg::res_t (value_res, last_res)
//
// Loading takes one word per cycle while the block waits for requests.
// After the last word, the walk takes each word through StRead and StCheck, and StSwap
// when a swap needs the single write port twice; emission takes each word through StEmRd
// and StEmOut, waiting out result stalls. No request is taken in the walk or emission.
// Reset returns the block to loading with an empty list; the store needs no clearing.
module sign_partition_engine #(
  parameter int unsigned DEPTH = spe_pkg::DepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  spe_pkg::req_t  req_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output spe_pkg::res_t  res_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [5:0] {
    StLoad  = 6'b000001,
    StRead  = 6'b000010,
    StCheck = 6'b000100,
    StSwap  = 6'b001000,
    StEmRd  = 6'b010000,
    StEmOut = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic [CntW-1:0] bnd_q, bnd_d;
  logic          res_valid_q, res_valid_d;
  spe_pkg::res_t res_q, res_d;

  logic                        we;
  logic [AW-1:0]               waddr;
  logic [spe_pkg::WordW-1:0]   wdata;
  logic                        re;
  logic [spe_pkg::WordW-1:0]   rdata_a;
  logic [spe_pkg::WordW-1:0]   rdata_b;
  logic                        req_fire;
  logic                        is_final;

  spe_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_i      (re),
    .raddr_a_i (scan_q[AW-1:0]),
    .raddr_b_i (bnd_q[AW-1:0]),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign req_ready_o = (state_q == StLoad);
  assign req_fire    = req_valid_i && req_ready_o;
  assign is_final    = ((scan_q + CntW'(1)) == count_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    bnd_d       = bnd_q;
    res_valid_d = res_valid_q;
    res_d       = res_q;
    we          = 1'b0;
    waddr       = count_q[AW-1:0];
    wdata       = req_i.value;
    re          = 1'b0;
    unique case (state_q)
      StLoad: begin
        if (req_fire) begin
          if (count_q < CntW'(DEPTH)) begin
            we      = 1'b1;
            count_d = count_q + CntW'(1);
          end
          if (req_i.last) begin
            scan_d  = '0;
            bnd_d   = '0;
            state_d = StRead;
          end
        end
      end
      StRead: begin
        if (scan_q == count_q) begin
          scan_d  = '0;
          state_d = StEmRd;
        end else begin
          re      = 1'b1;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (rdata_a[spe_pkg::WordW-1] && (scan_q != bnd_q)) begin
          we      = 1'b1;
          waddr   = scan_q[AW-1:0];
          wdata   = rdata_b;
          state_d = StSwap;
        end else begin
          if (rdata_a[spe_pkg::WordW-1]) begin
            bnd_d = bnd_q + CntW'(1);
          end
          scan_d  = scan_q + CntW'(1);
          state_d = StRead;
        end
      end
      StSwap: begin
        we      = 1'b1;
        waddr   = bnd_q[AW-1:0];
        wdata   = rdata_a;
        bnd_d   = bnd_q + CntW'(1);
        scan_d  = scan_q + CntW'(1);
        state_d = StRead;
      end
      StEmRd: begin
        re      = 1'b1;
        state_d = StEmOut;
      end
      StEmOut: begin
        if (!res_valid_q) begin
          res_valid_d     = 1'b1;
          res_d.value_res = rdata_a;
          res_d.last_res  = is_final;
        end else if (res_ready_i) begin
          res_valid_d = 1'b0;
          if (is_final) begin
            count_d = '0;
            scan_d  = '0;
            bnd_d   = '0;
            state_d = StLoad;
          end else begin
            scan_d  = scan_q + CntW'(1);
            state_d = StEmRd;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      count_q     <= '0;
      scan_q      <= '0;
      bnd_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      bnd_q       <= bnd_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ hdl/spe_ram.sv @@
// Word store of the sign partition engine.
// It has one write port and two read ports, and the read data is registered.
// Depends on spe_pkg.
module spe_ram #(
  parameter int unsigned DEPTH = spe_pkg::DepthDefault,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic [spe_pkg::WordW-1:0]      wdata_i,
  input  logic                           re_i,
  input  logic [AW-1:0]                  raddr_a_i,
  input  logic [AW-1:0]                  raddr_b_i,
  output logic [spe_pkg::WordW-1:0]      rdata_a_o,
  output logic [spe_pkg::WordW-1:0]      rdata_b_o
);

  logic [spe_pkg::WordW-1:0] mem_q [DEPTH];
  logic [spe_pkg::WordW-1:0] rdata_a_q;
  logic [spe_pkg::WordW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ tb/sv/sign_partition_engine_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sign_partition_engine: random and directed lists of signed
// words go in, and every emitted word is checked against a sign-partition predictor.
// Depends on spe_pkg and the sign_partition_engine RTL.
module sign_partition_engine_test;

  localparam int unsigned Depth    = spe_pkg::DepthDefault;
  localparam int unsigned WordW    = spe_pkg::WordW;
  localparam int unsigned StallMax = 4000;
  localparam int unsigned Drain    = 300;

  logic          clk_i     = 1'b0;
  logic          rst_ni    = 1'b0;
  logic          req_valid = 1'b0;
  logic          req_ready;
  spe_pkg::req_t req       = '0;
  logic          res_valid;
  logic          res_ready = 1'b0;
  spe_pkg::res_t res;

  spe_pkg::req_t pending_reqs[$];
  spe_pkg::res_t partition_expected[$];

  logic signed [WordW-1:0] stash[Depth];
  int stash_len      = 0;
  int requests_taken = 0;
  int words_checked  = 0;
  int mismatches     = 0;
  int stall_cycles   = 0;
  int lists_sent     = 0;
  int full_lists     = 0;

  sign_partition_engine #(
    .DEPTH(Depth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit take_break();
    bit calm;
    calm = requests_taken >= 120 && requests_taken < 240;
    return !calm && $urandom_range(0, 99) < 9;
  endfunction

  function automatic void absorb_request(spe_pkg::req_t r);
    int boundary;
    logic signed [WordW-1:0] w;
    spe_pkg::res_t e;
    if (stash_len < Depth) begin
      stash[stash_len] = r.value;
      stash_len++;
    end
    if (r.last) begin
      boundary = 0;
      while (boundary < stash_len && stash[boundary][WordW-1]) boundary++;
      for (int s = boundary + 1; s < stash_len; s++) begin
        if (stash[s][WordW-1]) begin
          w = stash[s];
          stash[s] = stash[boundary];
          stash[boundary] = w;
          boundary++;
        end
      end
      for (int k = 0; k < stash_len; k++) begin
        e.value_res = stash[k];
        e.last_res  = (k == stash_len - 1);
        partition_expected.push_back(e);
      end
      stash_len = 0;
    end
  endfunction

  function automatic void queue_word(logic signed [WordW-1:0] w, logic lst);
    spe_pkg::req_t r;
    r.value = w;
    r.last  = lst;
    pending_reqs.push_back(r);
    if (lst) lists_sent++;
  endfunction

  function automatic logic [WordW-1:0] rand_word(bit neg);
    logic [WordW-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 7))
      0: w = neg ? 32'h8000_0000 : 32'h7fff_ffff;
      1: w = neg ? 32'hffff_ffff : 32'h0000_0000;
      2: w = neg ? -$urandom_range(1, 16) : $urandom_range(0, 16);
      default: ;
    endcase
    w[WordW-1] = neg;
    return w;
  endfunction

  function automatic void queue_list(int len, int neg_pct);
    if (len > Depth) full_lists++;
    for (int i = 0; i < len; i++) begin
      queue_word(rand_word($urandom_range(0, 99) < neg_pct), i == len - 1);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req       <= '0;
    end else begin
      if (req_valid && req_ready) begin
        absorb_request(req);
        requests_taken++;
      end
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() != 0 && !take_break()) begin
          req_valid <= 1'b1;
          req       <= pending_reqs.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (partition_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value %0d last %0b",
                   $time, res.value_res, res.last_res);
          mismatches++;
        end else begin
          if (res.value_res !== partition_expected[0].value_res) begin
            $display("%0t: value_res mismatch, expected %0d, actual %0d", $time,
                     partition_expected[0].value_res, res.value_res);
            mismatches++;
          end
          if (res.last_res !== partition_expected[0].last_res) begin
            $display("%0t: last_res mismatch, expected %0b, actual %0b", $time,
                     partition_expected[0].last_res, res.last_res);
            mismatches++;
          end
          void'(partition_expected.pop_front());
        end
        words_checked++;
      end
      res_ready <= !take_break();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_valid && req_ready) || (res_valid && res_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= StallMax) begin
        $display("%0t: no handshake for %0d cycles", $time, StallMax);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    // Single words, extremes in a mixed list, all negative, all non-negative,
    // and leading negatives followed by a mix.
    queue_word(32'sd0, 1'b1);
    queue_word(-32'sd2147483648, 1'b1);
    queue_word(32'sd2147483647, 1'b0);
    queue_word(-32'sd1, 1'b0);
    queue_word(32'sd0, 1'b0);
    queue_word(-32'sd2147483648, 1'b0);
    queue_word(32'sd5, 1'b0);
    queue_word(-32'sd7, 1'b1);
    queue_word(-32'sd1, 1'b0);
    queue_word(-32'sd2147483648, 1'b0);
    queue_word(-32'sd100, 1'b1);
    queue_word(32'sd0, 1'b0);
    queue_word(32'sd2147483647, 1'b0);
    queue_word(32'sd1, 1'b1);
    queue_word(-32'sd3, 1'b0);
    queue_word(-32'sd4, 1'b0);
    queue_word(32'sd8, 1'b0);
    queue_word(-32'sd9, 1'b0);
    queue_word(32'sd0, 1'b0);
    queue_word(-32'sd1, 1'b1);

    // A list that exactly fills the store, then one whose closing words are dropped.
    queue_list(Depth, 50);
    queue_list(Depth + 2, 40);
    while (pending_reqs.size() < 325) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_list($urandom_range(Depth - 2, Depth + 4), $urandom_range(0, 4) * 25);
      end else begin
        queue_list($urandom_range(1, 12), $urandom_range(0, 4) * 25);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || req_valid || partition_expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (Drain) @(posedge clk_i);

    $display("Sent %0d lists (%0d longer than the store) in %0d requests.",
             lists_sent, full_lists, requests_taken);
    $display("Checked %0d partitioned words, %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0 && partition_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
